>>> hdl/sfq_pkg.sv
// Shared constants and types of the smallest-first request queue.
`default_nettype none

package sfq_pkg;

	// Default sizes.
	localparam int DEPTH    = 16;
	localparam int KEY_BITS = 32;
	localparam int TAG_BITS = 16;

	// Fixed field widths.
	localparam int CAP_W    = 5;
	localparam int OCC_W    = 5;
	localparam int STATUS_W = 2;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	// Capacity after reset.
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Register index of the capacity register.
	localparam logic REG_CAPACITY = 1'b0;

	// Operation codes.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// Result status codes.
	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_DONE  = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_cmd_t;

endpackage

`default_nettype wire

>>> hdl/sfq_ifs.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface sfq_in_if #(
	parameter int KEY_BITS = sfq_pkg::KEY_BITS,
	parameter int TAG_BITS = sfq_pkg::TAG_BITS
) ();
	logic                valid;
	logic                ready;
	logic                operation;
	logic [KEY_BITS-1:0] key;
	logic [TAG_BITS-1:0] tag;

	modport source (output valid, output operation, output key, output tag, input ready);
	modport sink   (input valid, input operation, input key, input tag, output ready);
endinterface

interface sfq_out_if #(
	parameter int KEY_BITS = sfq_pkg::KEY_BITS,
	parameter int TAG_BITS = sfq_pkg::TAG_BITS
) ();
	logic                         valid;
	logic                         ready;
	logic [sfq_pkg::STATUS_W-1:0] status;
	logic [KEY_BITS-1:0]          out_key;
	logic [TAG_BITS-1:0]          out_tag;
	logic [sfq_pkg::OCC_W-1:0]    occupancy;

	modport source (output valid, output status, output out_key, output out_tag,
		output occupancy, input ready);
	modport sink   (input valid, input status, input out_key, input out_tag,
		input occupancy, output ready);
endinterface

`default_nettype wire

>>> hdl/smallest_first_request_queue.sv
// Top level of the smallest-first request queue: a row of sorted cells and the result register.
//
//  Channel  Direction  Carries                                   Transfer when
//  in_ch    sink       operation, key, tag                       valid && ready
//  out_ch   source     status, out_key, out_tag, occupancy       valid && ready
//  APB      slave      capacity register at byte address 0       psel && penable && pwrite
//
// One request is taken per cycle. The whole row of cells updates at the edge that
// accepts the request, and the result is registered at that same edge, so the
// result appears in the next cycle. A request is taken while the result register is
// empty or its result is transferred in the same cycle; a stalled result holds.
// Reset empties every cell and sets the capacity to 16.
`default_nettype none

module smallest_first_request_queue #(
	parameter int DEPTH    = sfq_pkg::DEPTH,
	parameter int KEY_BITS = sfq_pkg::KEY_BITS,
	parameter int TAG_BITS = sfq_pkg::TAG_BITS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [sfq_pkg::PADDR_W-1:0] paddr,
	input  wire logic [sfq_pkg::PDATA_W-1:0] pwdata,
	output logic      [sfq_pkg::PDATA_W-1:0] prdata,
	output logic                             pready,
	sfq_in_if.sink                           in_ch,
	sfq_out_if.source                        out_ch
);

	localparam int CAP_W = sfq_pkg::CAP_W;
	localparam int OCC_W = sfq_pkg::OCC_W;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int EW    = ((CAP_W > CNT_W) ? CAP_W : CNT_W) + 1;

	logic [CAP_W-1:0]    capacity;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_next;
	logic [EW-1:0]       cap_ext;
	logic [EW-1:0]       eff_cap;
	logic                full;
	logic                empty;
	logic                in_fire;
	sfq_pkg::cell_cmd_t  cmd;
	sfq_pkg::status_t    status_next;

	logic                out_valid_q;
	sfq_pkg::status_t    status_q;
	logic [KEY_BITS-1:0] out_key_q;
	logic [TAG_BITS-1:0] out_tag_q;
	logic [OCC_W-1:0]    occ_q;

	logic                c_valid [DEPTH];
	logic                c_le    [DEPTH];
	logic [KEY_BITS-1:0] c_key   [DEPTH];
	logic [TAG_BITS-1:0] c_tag   [DEPTH];

	// Configuration registers.
	sfq_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	// Effective capacity: zero acts as one, anything above the depth as the depth.
	assign cap_ext = EW'(capacity);
	always_comb begin
		priority if (capacity == '0) begin
			eff_cap = EW'(1);
		end else if (cap_ext > EW'(DEPTH)) begin
			eff_cap = EW'(DEPTH);
		end else begin
			eff_cap = cap_ext;
		end
	end

	assign full  = (EW'(count_q) >= eff_cap);
	assign empty = (count_q == '0);

	// Request handshake: the result register is free or drains this cycle.
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_fire     = in_ch.valid && in_ch.ready;

	// Command to the row and the next count and status.
	always_comb begin
		cmd         = '0;
		count_next  = count_q;
		status_next = sfq_pkg::ST_DONE;
		unique case (in_ch.operation)
			sfq_pkg::OP_INSERT: begin
				if (full) begin
					status_next = sfq_pkg::ST_FULL;
				end else begin
					cmd.ins    = in_fire;
					count_next = count_q + CNT_W'(1);
				end
			end
			sfq_pkg::OP_REMOVE: begin
				if (empty) begin
					status_next = sfq_pkg::ST_EMPTY;
				end else begin
					cmd.rem    = in_fire;
					count_next = count_q - CNT_W'(1);
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Row of cells, head at index zero.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                p_valid;
		logic                p_le;
		logic [KEY_BITS-1:0] p_key;
		logic [TAG_BITS-1:0] p_tag;
		logic                n_valid;
		logic [KEY_BITS-1:0] n_key;
		logic [TAG_BITS-1:0] n_tag;

		if (i == 0) begin : g_head
			assign p_valid = 1'b1;
			assign p_le    = 1'b1;
			assign p_key   = in_ch.key;
			assign p_tag   = in_ch.tag;
		end else begin : g_mid
			assign p_valid = c_valid[i-1];
			assign p_le    = c_le[i-1];
			assign p_key   = c_key[i-1];
			assign p_tag   = c_tag[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_key   = c_key[i];
			assign n_tag   = c_tag[i];
		end else begin : g_body
			assign n_valid = c_valid[i+1];
			assign n_key   = c_key[i+1];
			assign n_tag   = c_tag[i+1];
		end

		sfq_cell #(
			.KEY_BITS (KEY_BITS),
			.TAG_BITS (TAG_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.in_key     (in_ch.key),
			.in_tag     (in_ch.tag),
			.prev_valid (p_valid),
			.prev_le    (p_le),
			.prev_key   (p_key),
			.prev_tag   (p_tag),
			.next_valid (n_valid),
			.next_key   (n_key),
			.next_tag   (n_tag),
			.valid      (c_valid[i]),
			.le         (c_le[i]),
			.key        (c_key[i]),
			.tag        (c_tag[i])
		);
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_fire) begin
			count_q <= count_next;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; a removed entry is read from the head cell.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			status_q <= status_next;
			occ_q    <= OCC_W'(count_next);
			if (cmd.rem) begin
				out_key_q <= c_key[0];
				out_tag_q <= c_tag[0];
			end else begin
				out_key_q <= '0;
				out_tag_q <= '0;
			end
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.status    = status_q;
	assign out_ch.out_key   = out_key_q;
	assign out_ch.out_tag   = out_tag_q;
	assign out_ch.occupancy = occ_q;

endmodule

`default_nettype wire

>>> hdl/sfq_cell.sv
// One slot of the sorted row: holds an entry and trades it with its neighbors.
`default_nettype none

module sfq_cell #(
	parameter int KEY_BITS = sfq_pkg::KEY_BITS,
	parameter int TAG_BITS = sfq_pkg::TAG_BITS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sfq_pkg::cell_cmd_t  cmd,
	input  wire logic [KEY_BITS-1:0] in_key,
	input  wire logic [TAG_BITS-1:0] in_tag,
	input  wire logic                prev_valid,
	input  wire logic                prev_le,
	input  wire logic [KEY_BITS-1:0] prev_key,
	input  wire logic [TAG_BITS-1:0] prev_tag,
	input  wire logic                next_valid,
	input  wire logic [KEY_BITS-1:0] next_key,
	input  wire logic [TAG_BITS-1:0] next_tag,
	output logic                     valid,
	output logic                     le,
	output logic [KEY_BITS-1:0]      key,
	output logic [TAG_BITS-1:0]      tag
);

	logic                valid_q;
	logic [KEY_BITS-1:0] key_q;
	logic [TAG_BITS-1:0] tag_q;
	logic                moves;

	// The entry stays in place when its key is not above the new key.
	assign le    = valid_q && (key_q <= in_key);
	assign moves = !le;

	// Occupancy of the slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins) begin
			if (moves) begin
				valid_q <= valid_q || prev_valid;
			end
		end else if (cmd.rem) begin
			valid_q <= next_valid;
		end
	end

	// Entry payload: on insert take the new entry or the left neighbor's, on remove the right one's.
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (moves) begin
				if (prev_le) begin
					key_q <= in_key;
					tag_q <= in_tag;
				end else begin
					key_q <= prev_key;
					tag_q <= prev_tag;
				end
			end
		end else if (cmd.rem) begin
			key_q <= next_key;
			tag_q <= next_tag;
		end
	end

	assign valid = valid_q;
	assign key   = key_q;
	assign tag   = tag_q;

endmodule

`default_nettype wire

>>> hdl/sfq_cfg.sv
// APB-style configuration register file holding the queue capacity.
`default_nettype none

module sfq_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [sfq_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [sfq_pkg::PDATA_W-1:0]   pwdata,
	output logic      [sfq_pkg::PDATA_W-1:0]   prdata,
	output logic                               pready,
	output logic      [sfq_pkg::CAP_W-1:0]     capacity
);

	localparam int CAP_W   = sfq_pkg::CAP_W;
	localparam int PDATA_W = sfq_pkg::PDATA_W;

	logic [CAP_W-1:0] capacity_q;
	logic             sel_cap;

	// Registers sit on 4-byte boundaries; the low address bits are ignored.
	assign sel_cap = (paddr[2] == sfq_pkg::REG_CAPACITY);
	assign pready  = 1'b1;

	// Capacity register, written in the access phase of a write transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= sfq_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && pready && sel_cap) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	// Read data.
	always_comb begin
		prdata = '0;
		if (sel_cap) begin
			prdata = PDATA_W'(capacity_q);
		end
	end

	assign capacity = capacity_q;

endmodule

`default_nettype wire

>>> verif/tb_smallest_first_request_queue.sv
// Self-checking testbench of the smallest-first request queue: directed table, then random phases.
`timescale 1ns / 100ps

module tb_smallest_first_request_queue;

	localparam int DEPTH    = sfq_pkg::DEPTH;
	localparam int KEY_BITS = sfq_pkg::KEY_BITS;
	localparam int TAG_BITS = sfq_pkg::TAG_BITS;
	localparam int CAP_W    = sfq_pkg::CAP_W;
	localparam int OCC_W    = sfq_pkg::OCC_W;
	localparam int PADDR_W  = sfq_pkg::PADDR_W;
	localparam int PDATA_W  = sfq_pkg::PDATA_W;

	localparam logic [CAP_W-1:0] CAP_RESET    = sfq_pkg::CAP_RESET;
	localparam logic             REG_CAPACITY = sfq_pkg::REG_CAPACITY;
	localparam logic             OP_INSERT    = sfq_pkg::OP_INSERT;
	localparam logic             OP_REMOVE    = sfq_pkg::OP_REMOVE;

	typedef sfq_pkg::status_t status_t;

	localparam status_t ST_DONE  = sfq_pkg::ST_DONE;
	localparam status_t ST_FULL  = sfq_pkg::ST_FULL;
	localparam status_t ST_EMPTY = sfq_pkg::ST_EMPTY;

	typedef struct packed {
		status_t             status;
		logic [KEY_BITS-1:0] out_key;
		logic [TAG_BITS-1:0] out_tag;
		logic [OCC_W-1:0]    occupancy;
	} outcome_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [TAG_BITS-1:0] tag;
	} entry_t;

	typedef enum logic {ROW_ITEM, ROW_CAP} row_kind_t;

	// One row of the directed table: a request or a capacity write.
	typedef struct packed {
		row_kind_t           kind;
		logic                op;
		logic [KEY_BITS-1:0] key;
		logic [TAG_BITS-1:0] tag;
		logic [CAP_W-1:0]    cap;
		logic                typed;
		outcome_t            want;
	} plan_row_t;

	localparam int PLAN_ROWS = 29;
	localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
		'{ROW_ITEM, OP_REMOVE, 32'h0, 16'h0, 5'd0, 1'b1, '{ST_EMPTY, 32'h0, 16'h0, 5'd0}},
		'{ROW_ITEM, OP_INSERT, 32'hFFFFFFFF, 16'hFFFF, 5'd0, 1'b1, '{ST_DONE, 32'h0, 16'h0, 5'd1}},
		'{ROW_ITEM, OP_INSERT, 32'h0, 16'h0, 5'd0, 1'b1, '{ST_DONE, 32'h0, 16'h0, 5'd2}},
		'{ROW_ITEM, OP_INSERT, 32'h5, 16'h1111, 5'd0, 1'b0, '0},
		'{ROW_ITEM, OP_INSERT, 32'h5, 16'h2222, 5'd0, 1'b0, '0},
		'{ROW_ITEM, OP_INSERT, 32'h5, 16'h3333, 5'd0, 1'b0, '0},
		'{ROW_ITEM, OP_INSERT, 32'hFFFFFFFF, 16'h0001, 5'd0, 1'b0, '0},
		'{ROW_ITEM, OP_INSERT, 32'h80000000, 16'h8000, 5'd0, 1'b0, '0},
		'{ROW_ITEM, OP_REMOVE, 32'h0, 16'h0, 5'd0, 1'b1, '{ST_DONE, 32'h0, 16'h0, 5'd6}},
		'{ROW_ITEM, OP_REMOVE, 32'h0, 16'h0, 5'd0, 1'b0, '0},
		'{ROW_ITEM, OP_REMOVE, 32'h0, 16'h0, 5'd0, 1'b0, '0},
		'{ROW_ITEM, OP_REMOVE, 32'h0, 16'h0, 5'd0, 1'b0, '0},
		'{ROW_ITEM, OP_REMOVE, 32'h0, 16'h0, 5'd0, 1'b0, '0},
		'{ROW_ITEM, OP_REMOVE, 32'h0, 16'h0, 5'd0, 1'b0, '0},
		'{ROW_ITEM, OP_REMOVE, 32'h0, 16'h0, 5'd0, 1'b1, '{ST_DONE, 32'hFFFFFFFF, 16'h0001, 5'd0}},
		'{ROW_ITEM, OP_REMOVE, 32'h0, 16'h0, 5'd0, 1'b1, '{ST_EMPTY, 32'h0, 16'h0, 5'd0}},
		'{ROW_CAP,  OP_INSERT, 32'h0, 16'h0, 5'd0, 1'b0, '0},
		'{ROW_ITEM, OP_INSERT, 32'hAAAAAAAA, 16'h5555, 5'd0, 1'b1, '{ST_DONE, 32'h0, 16'h0, 5'd1}},
		'{ROW_ITEM, OP_INSERT, 32'h1, 16'h1, 5'd0, 1'b1, '{ST_FULL, 32'h0, 16'h0, 5'd1}},
		'{ROW_CAP,  OP_INSERT, 32'h0, 16'h0, 5'd2, 1'b0, '0},
		'{ROW_ITEM, OP_INSERT, 32'h55555555, 16'hAAAA, 5'd0, 1'b0, '0},
		'{ROW_CAP,  OP_INSERT, 32'h0, 16'h0, 5'd1, 1'b0, '0},
		'{ROW_ITEM, OP_INSERT, 32'h0, 16'hFFFF, 5'd0, 1'b1, '{ST_FULL, 32'h0, 16'h0, 5'd2}},
		'{ROW_ITEM, OP_REMOVE, 32'h0, 16'h0, 5'd0, 1'b0, '0},
		'{ROW_ITEM, OP_INSERT, 32'h7, 16'h7, 5'd0, 1'b1, '{ST_FULL, 32'h0, 16'h0, 5'd1}},
		'{ROW_ITEM, OP_REMOVE, 32'h0, 16'h0, 5'd0, 1'b0, '0},
		'{ROW_ITEM, OP_INSERT, 32'h9, 16'h9, 5'd0, 1'b1, '{ST_DONE, 32'h0, 16'h0, 5'd1}},
		'{ROW_CAP,  OP_INSERT, 32'h0, 16'h0, 5'd31, 1'b0, '0},
		'{ROW_ITEM, OP_REMOVE, 32'h0, 16'h0, 5'd0, 1'b1, '{ST_DONE, 32'h9, 16'h9, 5'd0}}
	};

	localparam int PHASES     = 12;
	localparam int PHASE_ITEMS = 150;
	localparam logic [CAP_W-1:0] PHASE_CAPS [PHASES] = '{
		5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd4, 5'd2, 5'd16, 5'd9, 5'd3, 5'd15, 5'd16
	};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	sfq_in_if  in_ch ();
	sfq_out_if out_ch ();

	smallest_first_request_queue uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	// Shadow of the queue: entries in serving order, plus the capacity setting.
	entry_t           held_entries [$];
	logic [CAP_W-1:0] cap_setting = CAP_RESET;
	outcome_t         pending_results [$];

	int errors      = 0;
	int n_inserted  = 0;
	int n_turned    = 0;
	int n_removed   = 0;
	int n_dry       = 0;
	int n_cap_write = 0;
	bit send_idle   = 1'b1;
	bit sink_idle   = 1'b1;
	int stall_left  = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort if the run hangs.
	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Applies one request to the shadow queue and returns the result it must produce.
	function automatic outcome_t queue_outcome(input logic op, input logic [KEY_BITS-1:0] key,
		input logic [TAG_BITS-1:0] tag);
		outcome_t res;
		entry_t   ent;
		int       limit;
		int       pos;
		res = '0;
		res.status = ST_DONE;
		limit = (cap_setting == 0) ? 1 : ((cap_setting > DEPTH) ? DEPTH : int'(cap_setting));
		if (op == OP_INSERT) begin
			if (held_entries.size() >= limit) begin
				res.status = ST_FULL;
				n_turned++;
			end else begin
				// The new entry goes behind every entry with an equal or smaller key.
				pos = held_entries.size();
				while (pos > 0 && held_entries[pos-1].key > key)
					pos--;
				ent.key = key;
				ent.tag = tag;
				held_entries.insert(pos, ent);
				n_inserted++;
			end
		end else begin
			if (held_entries.size() == 0) begin
				res.status = ST_EMPTY;
				n_dry++;
			end else begin
				ent = held_entries.pop_front();
				res.out_key = ent.key;
				res.out_tag = ent.tag;
				n_removed++;
			end
		end
		res.occupancy = OCC_W'(held_entries.size());
		return res;
	endfunction

	// Random keys lean toward small values, so that equal keys are common, and the extremes.
	function automatic logic [KEY_BITS-1:0] pick_key();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: pick_key = KEY_BITS'($urandom());
			4, 5, 6:    pick_key = KEY_BITS'($urandom_range(0, 7));
			7:          pick_key = '0;
			8:          pick_key = {KEY_BITS{1'b1}};
			default:    pick_key = {KEY_BITS{1'b1}} - KEY_BITS'($urandom_range(1, 3));
		endcase
	endfunction

	// Offers one request, optionally after an idle burst, and records its expected result.
	task automatic send_request(input logic op, input logic [KEY_BITS-1:0] key,
		input logic [TAG_BITS-1:0] tag, input logic typed, input outcome_t typed_want);
		outcome_t res;
		int       gap;
		if (send_idle && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 11);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.operation <= op;
		in_ch.key       <= key;
		in_ch.tag       <= tag;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		res = queue_outcome(op, key, tag);
		pending_results.push_back(typed ? typed_want : res);
	endtask

	// Stops sending and waits until every outstanding result has been checked.
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Writes the capacity register while the block is idle, then reads it back.
	task automatic set_capacity(input logic [CAP_W-1:0] value);
		drain_results();
		repeat (3) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * REG_CAPACITY);
		pwdata  <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		cap_setting = value;
		n_cap_write++;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== PDATA_W'(value)) begin
			$error("prdata: expected %0d, got %0d", value, prdata);
			errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Result side: random stall bursts on ready, and a field-by-field check of each transfer.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d key %0h tag %0h occupancy %0d",
					out_ch.status, out_ch.out_key, out_ch.out_tag, out_ch.occupancy);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (out_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, out_ch.status);
					errors++;
				end
				if (out_ch.out_key !== want.out_key) begin
					$error("out_key: expected %0h, got %0h", want.out_key, out_ch.out_key);
					errors++;
				end
				if (out_ch.out_tag !== want.out_tag) begin
					$error("out_tag: expected %0h, got %0h", want.out_tag, out_ch.out_tag);
					errors++;
				end
				if (out_ch.occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, got %0d", want.occupancy,
						out_ch.occupancy);
					errors++;
				end
			end
		end
		if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else if (sink_idle && $urandom_range(0, 7) == 0) begin
			out_ch.ready <= 1'b0;
			stall_left   <= $urandom_range(1, 11) - 1;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Stimulus: reset, directed table, then random phases under several capacities.
	initial begin
		int   row;
		int   phase;
		int   item;
		int   run_left;
		logic run_op;
		logic [TAG_BITS-1:0] tag;

		in_ch.valid     <= 1'b0;
		in_ch.operation <= OP_INSERT;
		in_ch.key       <= '0;
		in_ch.tag       <= '0;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part.
		for (row = 0; row < PLAN_ROWS; row++) begin
			if (DIRECTED_PLAN[row].kind == ROW_CAP)
				set_capacity(DIRECTED_PLAN[row].cap);
			else
				send_request(DIRECTED_PLAN[row].op, DIRECTED_PLAN[row].key,
					DIRECTED_PLAN[row].tag, DIRECTED_PLAN[row].typed, DIRECTED_PLAN[row].want);
		end

		// Random part: runs of one operation push the queue to full and back to empty.
		run_left = 0;
		run_op   = OP_INSERT;
		for (phase = 0; phase < PHASES; phase++) begin
			set_capacity(PHASE_CAPS[phase]);
			send_idle = (phase != 6 && phase != PHASES - 1);
			sink_idle = send_idle;
			for (item = 0; item < PHASE_ITEMS; item++) begin
				if (run_left == 0) begin
					run_op   = ($urandom_range(0, 1) == 0) ? OP_INSERT : OP_REMOVE;
					run_left = $urandom_range(1, 20);
				end
				run_left--;
				tag = TAG_BITS'($urandom_range(0, 65535));
				send_request(run_op, pick_key(), tag, 1'b0, '0);
				// Let the queue settle completely once in the middle of a phase.
				if (phase == 3 && item == PHASE_ITEMS / 2)
					drain_results();
			end
		end

		drain_results();
		repeat (5) @(posedge clk);
		$display("Run covered %0d inserts, %0d full rejections, %0d removals, %0d empty removals,",
			n_inserted, n_turned, n_removed, n_dry);
		$display("under %0d capacity writes including 0, 1, 16, 17 and 31.", n_cap_write);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> files.f
hdl/sfq_pkg.sv
hdl/sfq_ifs.sv
hdl/sfq_cell.sv
hdl/sfq_cfg.sv
hdl/smallest_first_request_queue.sv
verif/tb_smallest_first_request_queue.sv
